FILE: sv/lap3_pkg.sv
// shared types, constants and kernel arithmetic for the laplacian gray filter
`default_nettype none

package lap3_pkg;

  localparam int PIX_W          = 8;
  localparam int SUM_W          = 12;
  localparam int DIM_W          = 13;
  localparam int WIDTH_REG_W    = 11;
  localparam int HEIGHT_REG_W   = 13;
  localparam int ROW_W          = 12;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT     = 4096;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;
  localparam int GRAY_SUM_W     = 10;
  localparam int RECIP_3        = 683;
  localparam int RECIP_SHIFT    = 11;
  localparam int RECIP_PROD_W   = 20;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;
  localparam int KCOL_CUR       = 2;

  // kernel indexed [row][column], row 0 is the oldest line
  localparam int KERNEL [3][3] = '{'{0, -1, 0}, '{-1, 4, -1}, '{0, -1, 0}};

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } lap3_reg_e;

  // one window column: two rows up, one row up, current row
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } lap3_col_t;

  function automatic logic signed [SUM_W-1:0] lap3_col_sum(input int kcol,
                                                           input lap3_col_t col);
    int acc;
    acc = KERNEL[0][kcol] * int'(col.top)
        + KERNEL[1][kcol] * int'(col.mid)
        + KERNEL[2][kcol] * int'(col.bot);
    return SUM_W'(acc);
  endfunction

endpackage

`default_nettype wire

FILE: sv/lap3_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module lap3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/lap3_cell.sv
// one window column cell: holds a column and hands it to the next older cell
`default_nettype none

module lap3_cell
  import lap3_pkg::*;
#(
  parameter int KCOL = 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    shift_i,
  input  wire lap3_col_t               col_i,
  output lap3_col_t                    col_o,
  output logic signed [SUM_W-1:0]      part_o
);

  lap3_col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o  = col_q;
  assign part_o = lap3_col_sum(KCOL, col_q);

endmodule

`default_nettype wire

FILE: sv/laplacian_3x3_gray_filter_unit.sv
// top level of the 3x3 laplacian filter on gray-converted rgb pixels
`default_nettype none

// Takes one rgb pixel per clock in raster order and returns one filtered gray
// pixel per clock while no stall holds the flow, one item out for each item in;
// the line store read is registered in stage 1, then the kernel sum goes into
// the output register. The window is a chain of two column cells fed from two
// line stores of MAX_WIDTH entries. After reset all MAX_WIDTH entries (1024 by
// default) are cleared, during which in_stall_o stays high; configuration
// writes are taken at any time. The output is 0 while the window reaches above
// row 0 or left of column 0; frame_end_o marks the last pixel of each frame.
module laplacian_3x3_gray_filter_unit
  import lap3_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [PIX_W-1:0]      red_i,
  input  wire logic [PIX_W-1:0]      green_i,
  input  wire logic [PIX_W-1:0]      blue_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [PIX_W-1:0]      filtered_o,
  output logic                       frame_end_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  // configuration
  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic                    cfg_we;
  lap3_reg_e               cfg_idx;

  // position and clearing pass
  logic [CW-1:0]     col_cnt_q, col_cnt_d;
  logic [ROW_W-1:0]  row_cnt_q, row_cnt_d;
  logic              clearing_q;
  logic [CW-1:0]     clr_q;

  // accept side
  logic               in_acc;
  logic [DIM_W-1:0]   w_eff, h_eff, wm1, hm1;
  logic [CW-1:0]      c_cur;
  logic [ROW_W-1:0]   r_cur;
  logic               inner, last;
  logic [GRAY_SUM_W-1:0]   gray_sum;
  logic [RECIP_PROD_W-1:0] gray_prod;
  logic [PIX_W-1:0]        gray;

  // stage 1
  logic              s1_valid_q;
  logic [PIX_W-1:0]  s1_gray_q;
  logic [CW-1:0]     s1_addr_q;
  logic              s1_inner_q, s1_last_q;
  logic              s1_fwd_q;
  logic [PIX_W-1:0]  s1_fwd_a_q, s1_fwd_b_q;
  logic              s1_adv;
  logic [PIX_W-1:0]  one_up, two_up;
  logic [PIX_W-1:0]  ram_a_rd, ram_b_rd;

  // ram write port
  logic              ram_we;
  logic [CW-1:0]     ram_waddr;
  logic [PIX_W-1:0]  ram_a_wd, ram_b_wd;

  // window and kernel
  lap3_col_t                  win_col [3];
  logic signed [SUM_W-1:0]    part [3];
  logic signed [SUM_W-1:0]    ksum;
  logic [PIX_W-1:0]           clamped;

  // output register
  logic              out_valid_q;
  logic [PIX_W-1:0]  filtered_q;
  logic              frame_end_q;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_idx = lap3_reg_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_REG_W'(WIDTH_RESET);
      height_q <= HEIGHT_REG_W'(HEIGHT_RESET);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  width_q  <= pwdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_q);
      REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- position
  always_comb begin
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (DIM_W'(width_q) > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(width_q);
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (DIM_W'(height_q) > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = DIM_W'(height_q);
    end
  end

  assign wm1 = w_eff - DIM_W'(1);
  assign hm1 = h_eff - DIM_W'(1);

  // counters past the current size stand on the last column or row
  assign c_cur = (DIM_W'(col_cnt_q) >= wm1) ? wm1[CW-1:0] : col_cnt_q;
  assign r_cur = (DIM_W'(row_cnt_q) >= hm1) ? hm1[ROW_W-1:0] : row_cnt_q;
  assign inner = (r_cur >= ROW_W'(2)) && (c_cur >= CW'(2));
  assign last  = (DIM_W'(r_cur) == hm1) && (DIM_W'(c_cur) == wm1);

  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (in_acc) begin
      if (DIM_W'(c_cur) == wm1) begin
        col_cnt_d = '0;
        row_cnt_d = last ? '0 : r_cur + ROW_W'(1);
      end else begin
        col_cnt_d = c_cur + CW'(1);
        row_cnt_d = r_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  // line stores are zeroed once after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + CW'(1);
      if (clr_q == CW'(MAX_WIDTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- accept
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clearing_q || (s1_valid_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;

  // divide by 3 through the reciprocal, exact for sums up to 765
  assign gray_sum  = GRAY_SUM_W'(red_i) + GRAY_SUM_W'(green_i) + GRAY_SUM_W'(blue_i);
  assign gray_prod = RECIP_PROD_W'(gray_sum) * RECIP_PROD_W'(RECIP_3);
  assign gray      = gray_prod[RECIP_SHIFT +: PIX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // same column twice in a row (one-pixel rows) needs the unwritten values
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_gray_q  <= gray;
      s1_addr_q  <= c_cur;
      s1_inner_q <= inner;
      s1_last_q  <= last;
      s1_fwd_q   <= s1_adv && (s1_addr_q == c_cur);
      s1_fwd_a_q <= s1_gray_q;
      s1_fwd_b_q <= one_up;
    end
  end

  // ---------------------------------------------------------------- line stores
  assign ram_we    = clearing_q || s1_adv;
  assign ram_waddr = clearing_q ? clr_q : s1_addr_q;
  assign ram_a_wd  = clearing_q ? '0 : s1_gray_q;
  assign ram_b_wd  = clearing_q ? '0 : one_up;

  lap3_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_a (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_a_wd),
    .re_i   (in_acc),
    .raddr_i(c_cur),
    .rdata_o(ram_a_rd)
  );

  lap3_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_b (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_b_wd),
    .re_i   (in_acc),
    .raddr_i(c_cur),
    .rdata_o(ram_b_rd)
  );

  assign one_up = s1_fwd_q ? s1_fwd_a_q : ram_a_rd;
  assign two_up = s1_fwd_q ? s1_fwd_b_q : ram_b_rd;

  // ---------------------------------------------------------------- window
  assign win_col[0].top = two_up;
  assign win_col[0].mid = one_up;
  assign win_col[0].bot = s1_gray_q;
  assign part[0]        = lap3_col_sum(KCOL_CUR, win_col[0]);

  // cell k holds column c-1-k
  for (genvar k = 0; k < 2; k++) begin : g_cell
    lap3_cell #(
      .KCOL(KCOL_CUR - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(s1_adv),
      .col_i  (win_col[k]),
      .col_o  (win_col[k+1]),
      .part_o (part[k+1])
    );
  end

  assign ksum = part[0] + part[1] + part[2];

  always_comb begin
    if (ksum[SUM_W-1]) begin
      clamped = '0;
    end else if (|ksum[SUM_W-2:PIX_W]) begin
      clamped = '1;
    end else begin
      clamped = ksum[PIX_W-1:0];
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      filtered_q  <= s1_inner_q ? clamped : '0;
      frame_end_q <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign frame_end_o = frame_end_q;

`ifndef SYNTHESIS
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> (!s1_valid_q && !out_valid_q))
    else $error("pipeline holds an item during the line store clear");

  a_fwd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !s1_adv) |=> !s1_fwd_q)
    else $error("bypass taken without a write of the previous item");

  a_acc_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted item lost before the window stage");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("window stage advanced without a result");
`endif

endmodule

`default_nettype wire

FILE: verif/laplacian_3x3_gray_filter_checker.sv
// checker for the laplacian 3x3 gray filter: predicts each item and compares the results
module laplacian_3x3_gray_filter_checker
  import lap3_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel_i,
  input  wire logic                  penable_i,
  input  wire logic                  pwrite_i,
  input  wire logic [APB_ADDR_W-1:0] paddr_i,
  input  wire logic [APB_DATA_W-1:0] pwdata_i,
  input  wire logic                  pready_i,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_i,
  input  wire logic [PIX_W-1:0]      red_i,
  input  wire logic [PIX_W-1:0]      green_i,
  input  wire logic [PIX_W-1:0]      blue_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_stall_i,
  input  wire logic [PIX_W-1:0]      filtered_i,
  input  wire logic                  frame_end_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  typedef struct packed {
    logic [PIX_W-1:0] filtered;
    logic             frame_end;
  } lap3_result_t;

  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [PIX_W-1:0]        above_line [MAX_WIDTH];
  logic [PIX_W-1:0]        two_above_line [MAX_WIDTH];
  // window columns at c-1 and c-2
  lap3_col_t               left_col;
  lap3_col_t               left2_col;
  int                      col_pos;
  int                      row_pos;
  lap3_result_t            expected_pixels [$];
  int                      mismatches;

  function automatic int fold_dim(input int value, input int hi);
    if (value == 0) return 1;
    return (value > hi) ? hi : value;
  endfunction

  task automatic predict_laplacian(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                   input logic [PIX_W-1:0] b);
    int               w;
    int               h;
    int               c;
    int               rw;
    int               acc;
    logic [PIX_W-1:0] gray;
    logic [PIX_W-1:0] up2;
    logic [PIX_W-1:0] up1;
    lap3_result_t     res;
    w = fold_dim(int'(width_reg), MAX_WIDTH);
    h = fold_dim(int'(height_reg), MAX_HEIGHT);
    // counters past a shrunk frame count as the last column or row
    c = (col_pos >= w) ? w - 1 : col_pos;
    rw = (row_pos >= h) ? h - 1 : row_pos;
    gray = PIX_W'((int'(r) + int'(g) + int'(b)) / 3);
    up2 = two_above_line[c];
    up1 = above_line[c];
    // center sits one row up and one column left of the current pixel
    acc = 4 * int'(left_col.mid) - int'(left_col.top) - int'(left2_col.mid)
        - int'(up1) - int'(left_col.bot);
    res.filtered = '0;
    if (rw >= 2 && c >= 2) begin
      res.filtered = (acc < 0) ? '0 : (acc > 255) ? 8'hff : PIX_W'(acc);
    end
    res.frame_end = (rw == h - 1) && (c == w - 1);
    two_above_line[c] = up1;
    above_line[c] = gray;
    left2_col = left_col;
    left_col = '{top: up2, mid: up1, bot: gray};
    if (c == w - 1) begin
      col_pos = 0;
      row_pos = res.frame_end ? 0 : rw + 1;
    end else begin
      col_pos = c + 1;
      row_pos = rw;
    end
    expected_pixels.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lap3_result_t want;
    if (!rst_ni) begin
      width_reg = WIDTH_REG_W'(WIDTH_RESET);
      height_reg = HEIGHT_REG_W'(HEIGHT_RESET);
      for (int i = 0; i < MAX_WIDTH; i++) begin
        above_line[i] = '0;
        two_above_line[i] = '0;
      end
      left_col = '0;
      left2_col = '0;
      col_pos = 0;
      row_pos = 0;
      expected_pixels.delete();
      mismatches = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (lap3_reg_e'(paddr_i[APB_ADDR_W-1:2]))
          REG_IMAGE_WIDTH:  width_reg = pwdata_i[WIDTH_REG_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = pwdata_i[HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_laplacian(red_i, green_i, blue_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected item filtered=%0d frame_end=%0b",
                     $time, filtered_i, frame_end_i);
          end
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (filtered_i !== want.filtered || frame_end_i !== want.frame_end) begin
            if (mismatches < 10) begin
              $display("%0t: item mismatch filtered=%0d (expected %0d) frame_end=%0b (expected %0b)",
                       $time, filtered_i, want.filtered, frame_end_i, want.frame_end);
            end
            mismatches++;
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o <= expected_pixels.size();
  end

endmodule

FILE: verif/laplacian_3x3_gray_filter_unit_tb.sv
// testbench top for the laplacian 3x3 gray filter: stimulus, idling and verdict
module laplacian_3x3_gray_filter_unit_tb;
  import lap3_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [PIX_W-1:0]      red_i = '0;
  logic [PIX_W-1:0]      green_i = '0;
  logic [PIX_W-1:0]      blue_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PIX_W-1:0]      filtered_o;
  logic                  frame_end_o;
  int                    fail_count;
  int                    pending_items;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;

  // three 3x3 frames of gray levels: clamp high, clamp low, in range (100)
  logic [PIX_W-1:0] directed_gray [27] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
    8'd9,   8'd90,  8'd9,   8'd80,  8'd100, 8'd70,  8'd9,   8'd60,  8'd9
  };

  laplacian_3x3_gray_filter_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .filtered_o (filtered_o),
    .frame_end_o(frame_end_o)
  );

  laplacian_3x3_gray_filter_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pready_i    (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_i  (filtered_o),
    .frame_end_i (frame_end_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_items)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic reg_write(input lap3_reg_e idx, input logic [APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // valid stays up after an accepted item so back-to-back items need no toggle
  task automatic push_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic push_random(input int style);
    logic [PIX_W-1:0] v;
    case (style)
      2: begin
        // hard edges drive the response into both clamps
        v = $urandom_range(1) ? 8'hff : 8'h00;
        push_pixel(v, v, v);
      end
      3: begin
        v = PIX_W'($urandom_range(100, 140));
        push_pixel(v, PIX_W'(v + $urandom_range(3)), v);
      end
      default: push_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
    endcase
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_items != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // new sizes can land mid-frame; the counters carry over
  task automatic random_phase();
    int pick;
    int style;
    int n;
    pick = $urandom_range(11);
    style = $urandom_range(3);
    n = $urandom_range(8, 45);
    if (pick < 7) begin
      reg_write(REG_IMAGE_WIDTH, $urandom_range(3, 12));
      reg_write(REG_IMAGE_HEIGHT, $urandom_range(3, 6));
    end else if (pick == 7) begin
      // degenerate frames, zero acts as one
      reg_write(REG_IMAGE_WIDTH, $urandom_range(0, 2));
      reg_write(REG_IMAGE_HEIGHT, $urandom_range(0, 2));
    end else if (pick == 8) begin
      reg_write(REG_IMAGE_WIDTH, $urandom_range(3, 12));
    end else if (pick == 9) begin
      reg_write(REG_IMAGE_HEIGHT, $urandom_range(1, 5));
    end else if (pick == 10) begin
      reg_write(REG_IMAGE_WIDTH, $urandom);
      reg_write(REG_IMAGE_HEIGHT, $urandom);
    end
    repeat (n) push_random(style);
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 9;
    recv_idle_pct = 56;
    reg_write(REG_IMAGE_WIDTH, 3);
    reg_write(REG_IMAGE_HEIGHT, 3);
    for (int k = 0; k < 27; k++) begin
      int               s;
      logic [PIX_W-1:0] cr;
      logic [PIX_W-1:0] cg;
      // spread 3*gray plus a remainder over the channels to exercise truncation
      s = 3 * int'(directed_gray[k]) + ((directed_gray[k] < 8'd255) ? k % 3 : 0);
      cr = (s > 255) ? 8'hff : PIX_W'(s);
      s = s - int'(cr);
      cg = (s > 255) ? 8'hff : PIX_W'(s);
      s = s - int'(cg);
      push_pixel(cr, cg, PIX_W'(s));
    end
    drain();
    repeat (6) random_phase();

    send_idle_pct = 56;
    recv_idle_pct = 9;
    repeat (6) random_phase();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) random_phase();

    // oversized width folds to MAX_WIDTH
    reg_write(REG_IMAGE_WIDTH, 2047);
    reg_write(REG_IMAGE_HEIGHT, 3);
    repeat (30) push_random($urandom_range(2));
    drain();

    // one column and an oversized height that folds to MAX_HEIGHT rows
    reg_write(REG_IMAGE_WIDTH, 0);
    reg_write(REG_IMAGE_HEIGHT, 8191);
    repeat (30) push_random($urandom_range(2));
    drain();

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule
